// ===== rtl/core/percentile_select_macros.svh =====
// ----------------------------------------------------------------------------
// percentile_select_macros
// Assertion shorthands shared by the percentile selector RTL.
// ----------------------------------------------------------------------------
`ifndef PERCENTILE_SELECT_MACROS_SVH
`define PERCENTILE_SELECT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/psel_pkg.sv =====
// ----------------------------------------------------------------------------
// psel_pkg
// Widths and constants of the nearest-rank percentile selector.
// ----------------------------------------------------------------------------
package psel_pkg;

  localparam int unsigned DEPTH_DEF   = 1024;
  localparam int unsigned SAMPLE_W    = 64;
  localparam int unsigned TENTHS_W    = 10;
  localparam int unsigned TENTHS_FULL = 1000;

  // input operation codes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // floor(n / 1000) = (n * RECIP_M) >> RECIP_SHIFT, exact for n < 2^27
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP_M = 27'd68719477;

endpackage

// ===== rtl/core/percentile_select.sv =====
// ----------------------------------------------------------------------------
// percentile_select
// Collects unsigned 64-bit samples in sorted order and answers
// nearest-rank percentile queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): in_mode 0 adds in_sample to the
//   store, in_mode 1 queries the percentile in_percent_tenths (0.1 %).
//   Output channel (out_valid/out_stall): one transfer per query carrying
//   out_value, out_empty_res and the sticky out_overflowed flag.
// Timing:
//   An add shifts the held samples larger than the new one: each cycle
//   moves one entry up by one place through the sample memory (one read
//   port, one write port, registered read).
//   A full store drops the sample and sets the overflow flag.
//   A query passes through scale, reciprocal multiply by 1/1000, memory
//   read and output load before out_valid rises; the next item is
//   accepted once the sequencer is back in idle after the output load.
//   in_stall is high while an item is in progress.
// Stall:
//   The result waits in the output register; adds are still accepted
//   meanwhile, a following query holds before its output load.
// Reset:
//   rst_n (synchronous, active low) empties the store and clears the
//   overflow flag. The memory contents are not cleared; only entries
//   below the sample count are ever used.
// ----------------------------------------------------------------------------
`include "percentile_select_macros.svh"

module percentile_select #(
  parameter int unsigned DEPTH = psel_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [psel_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic [psel_pkg::TENTHS_W-1:0]   in_percent_tenths,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [psel_pkg::SAMPLE_W-1:0]   out_value,
  output logic                            out_empty_res,
  output logic                            out_overflowed
);

  import psel_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = TENTHS_W + CW;
  localparam int unsigned QW = NW + RECIP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // sample store
  logic [SAMPLE_W-1:0] mem [DEPTH];

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                dropped_r, dropped_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [TENTHS_W-1:0] tenths_r, tenths_nxt;
  logic [NW-1:0]       num_r, num_nxt;
  logic [QW-1:0]       quot_r, quot_nxt;
  logic [SAMPLE_W-1:0] rd_data_r;

  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                re, we;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                in_xfer, out_xfer, store_full;
  logic [CW-1:0]       rank;

  assign in_xfer    = in_valid && !in_stall;
  assign out_xfer   = out_valid_r && !out_stall;
  assign store_full = (count_r == CW'(DEPTH));
  assign rank       = quot_r[RECIP_SHIFT +: CW];

  // Sequencer: insertion shift loop and query pipeline
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    pos_nxt       = pos_r;
    sample_nxt    = sample_r;
    tenths_nxt    = tenths_r;
    num_nxt       = num_r;
    quot_nxt      = quot_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_value_nxt = out_value_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    re            = 1'b0;
    rd_addr       = '0;
    we            = 1'b0;
    wr_addr       = pos_r;
    wr_data       = sample_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_mode == MODE_QUERY) begin
            // clamp percentile to 1..1000
            if (in_percent_tenths == '0) begin
              tenths_nxt = TENTHS_W'(1);
            end else if (in_percent_tenths > TENTHS_W'(TENTHS_FULL)) begin
              tenths_nxt = TENTHS_W'(TENTHS_FULL);
            end else begin
              tenths_nxt = in_percent_tenths;
            end
            state_nxt = S_MUL;
          end else if (store_full) begin
            dropped_nxt = 1'b1;
          end else begin
            // start at the top of the store, fetch the last held entry
            sample_nxt = in_sample;
            pos_nxt    = count_r[AW-1:0];
            re         = 1'b1;
            rd_addr    = count_r[AW-1:0] - AW'(1);
            state_nxt  = S_INS;
          end
        end
      end
      S_INS: begin
        we = 1'b1;
        if (pos_r != '0 && rd_data_r > sample_r) begin
          // move the larger entry up, fetch the next one down if any
          wr_data   = rd_data_r;
          pos_nxt   = pos_r - AW'(1);
          re        = (pos_r != AW'(1));
          rd_addr   = pos_r - AW'(2);
        end else begin
          // drop the new sample into the hole
          wr_data   = sample_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        num_nxt   = NW'(tenths_r) * NW'(count_r) + NW'(TENTHS_FULL - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quot_nxt  = QW'(num_r) * QW'(RECIP_M);
        state_nxt = S_RD;
      end
      S_RD: begin
        re        = 1'b1;
        rd_addr   = AW'(rank - CW'(1));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = (count_r == '0);
          out_value_nxt = (count_r == '0) ? '0 : rd_data_r;
          out_ovf_nxt   = dropped_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    sample_r    <= sample_nxt;
    tenths_r    <= tenths_nxt;
    num_r       <= num_nxt;
    quot_r      <= quot_nxt;
    out_value_r <= out_value_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_empty_res  = out_empty_r;
  assign out_overflowed = out_ovf_r;

  `PS_ASSERT_NEXT(a_drop_on_full, in_xfer && (in_mode == MODE_ADD) && store_full,
                  dropped_r, "full add not flagged")
  `PS_ASSERT_NEXT(a_drop_sticky, dropped_r, dropped_r, "overflow flag cleared")
  `PS_ASSERT_NEXT(a_count_step, 1'b1,
                  (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)),
                  "count moved by more than one")
  `PS_ASSERT_NOW(a_no_rw_clash, we && re, wr_addr != rd_addr,
                 "read and write hit the same entry")

endmodule
